// ----- src/jbed_pkg.sv -----
// Shared types, register codes, event codes and reset values for the joystick event decoder.
`default_nettype none

package jbed_pkg;

    localparam int ADC_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF = 14;

    localparam int CENTER_W   = 12;
    localparam int SPAN_W     = 12;
    localparam int HALF_W     = SPAN_W - 1;
    localparam int MS_W       = 16;
    localparam int THR_W      = 15;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_OUT_W  = 16;
    localparam int EVENT_W    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_CENTER     = 3'd0,
        REG_Y_CENTER     = 3'd1,
        REG_X_SPAN       = 3'd2,
        REG_Y_SPAN       = 3'd3,
        REG_REPEAT_DELAY = 3'd4,
        REG_DEADBAND     = 3'd5,
        REG_ACCEL_THR    = 3'd6,
        REG_HOLD_TIME    = 3'd7
    } cfg_idx_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 4'd0,
        EV_BOTH_HOLD = 4'd1,
        EV_BUTTON1   = 4'd2,
        EV_BUTTON2   = 4'd3,
        EV_RIGHT     = 4'd4,
        EV_LEFT      = 4'd5,
        EV_SCR_RIGHT = 4'd6,
        EV_SCR_LEFT  = 4'd7,
        EV_UP        = 4'd8,
        EV_DOWN      = 4'd9
    } event_t;

    typedef struct packed {
        logic [CENTER_W-1:0] x_center;
        logic [CENTER_W-1:0] y_center;
        logic [SPAN_W-1:0]   x_span;
        logic [SPAN_W-1:0]   y_span;
        logic [MS_W-1:0]     repeat_delay_ms;
        logic [THR_W-1:0]    deadband;
        logic [THR_W-1:0]    accel_threshold;
        logic [MS_W-1:0]     hold_time_ms;
    } cfg_t;

    typedef struct packed {
        event_t                 event_code;
        logic [POS_OUT_W-1:0]   x_pos;
        logic [POS_OUT_W-1:0]   y_pos;
        logic                   x_engaged;
        logic                   y_engaged;
        logic                   accel_active;
    } res_t;

    localparam logic [CENTER_W-1:0] X_CENTER_RST     = 12'd2048;
    localparam logic [CENTER_W-1:0] Y_CENTER_RST     = 12'd2048;
    localparam logic [SPAN_W-1:0]   X_SPAN_RST       = 12'd1800;
    localparam logic [SPAN_W-1:0]   Y_SPAN_RST       = 12'd1800;
    localparam logic [MS_W-1:0]     REPEAT_DELAY_RST = 16'd200;
    localparam logic [THR_W-1:0]    DEADBAND_RST     = 15'd1638;
    localparam logic [THR_W-1:0]    ACCEL_THR_RST    = 15'd13107;
    localparam logic [MS_W-1:0]     HOLD_TIME_RST    = 16'd3000;

endpackage

`default_nettype wire

// ----- src/jbed_cfg_regs.sv -----
// Configuration register file written through a plain write port.
`default_nettype none

module jbed_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [jbed_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [jbed_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output jbed_pkg::cfg_t                       cfg
);
    import jbed_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_center        <= X_CENTER_RST;
            cfg_reg.y_center        <= Y_CENTER_RST;
            cfg_reg.x_span          <= X_SPAN_RST;
            cfg_reg.y_span          <= Y_SPAN_RST;
            cfg_reg.repeat_delay_ms <= REPEAT_DELAY_RST;
            cfg_reg.deadband        <= DEADBAND_RST;
            cfg_reg.accel_threshold <= ACCEL_THR_RST;
            cfg_reg.hold_time_ms    <= HOLD_TIME_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_X_CENTER:     cfg_reg.x_center        <= cfg_wr_data[CENTER_W-1:0];
                REG_Y_CENTER:     cfg_reg.y_center        <= cfg_wr_data[CENTER_W-1:0];
                REG_X_SPAN:       cfg_reg.x_span          <= cfg_wr_data[SPAN_W-1:0];
                REG_Y_SPAN:       cfg_reg.y_span          <= cfg_wr_data[SPAN_W-1:0];
                REG_REPEAT_DELAY: cfg_reg.repeat_delay_ms <= cfg_wr_data[MS_W-1:0];
                REG_DEADBAND:     cfg_reg.deadband        <= cfg_wr_data[THR_W-1:0];
                REG_ACCEL_THR:    cfg_reg.accel_threshold <= cfg_wr_data[THR_W-1:0];
                REG_HOLD_TIME:    cfg_reg.hold_time_ms    <= cfg_wr_data[MS_W-1:0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/jbed_axis_div.sv -----
// Bit-serial axis scaler: magnitude of (raw - center) * 2^FRAC_BITS / (span / 2), clamped.
`default_nettype none

module jbed_axis_div #(
    parameter int ADC_BITS  = jbed_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = jbed_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [ADC_BITS-1:0]           raw,
    input  wire logic [jbed_pkg::CENTER_W-1:0] center,
    input  wire logic [jbed_pkg::SPAN_W-1:0]   span,
    output logic                               done,
    output logic [FRAC_BITS:0]                 mag,
    output logic                               neg
);
    import jbed_pkg::*;

    localparam int QW    = ADC_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);
    localparam logic [QW-1:0]    ONE_Q = QW'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(QW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [QW-1:0]       num_reg;
    logic [HALF_W-1:0]   rem_reg;
    logic [HALF_W-1:0]   half_reg;
    logic [QW-1:0]       quot_reg;
    logic                neg_reg;

    logic [ADC_BITS-1:0] center_m;
    logic [ADC_BITS:0]   diff;
    logic [ADC_BITS:0]   diff_inv;
    logic                diff_neg;
    logic [ADC_BITS-1:0] abs_diff;
    logic [HALF_W-1:0]   half_in;
    logic [HALF_W:0]     trial;
    logic [HALF_W:0]     trial_sub;
    logic                fits;
    logic [HALF_W-1:0]   rem_next;

    assign center_m = ADC_BITS'(center);
    assign diff     = {1'b0, raw} - {1'b0, center_m};
    assign diff_inv = -diff;
    assign diff_neg = diff[ADC_BITS];
    assign abs_diff = diff_neg ? diff_inv[ADC_BITS-1:0] : diff[ADC_BITS-1:0];
    assign half_in  = span[SPAN_W-1:1];

    // One quotient bit per cycle, restoring division.
    assign trial     = {rem_reg, num_reg[QW-1]};
    assign trial_sub = trial - {1'b0, half_reg};
    assign fits      = trial >= {1'b0, half_reg};
    assign rem_next  = fits ? trial_sub[HALF_W-1:0] : trial[HALF_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                neg_reg <= diff_neg;
                if (half_in == '0) begin
                    quot_reg <= (abs_diff != '0) ? ONE_Q : '0;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_LOAD;
                    num_reg  <= QW'(abs_diff) << FRAC_BITS;
                    rem_reg  <= '0;
                    half_reg <= half_in;
                    quot_reg <= '0;
                end
            end else if (busy_reg) begin
                num_reg  <= num_reg << 1;
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[QW-2:0], fits};
                cnt_reg  <= cnt_reg - CNT_LAST;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign mag  = (quot_reg > ONE_Q) ? ONE_Q[FRAC_BITS:0] : quot_reg[FRAC_BITS:0];

endmodule

`default_nettype wire

// ----- src/jbed_event_unit.sv -----
// Deadband, button edge and hold timer, and rate-limited stick event decision.
`default_nettype none

module jbed_event_unit #(
    parameter int FRAC_BITS = jbed_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        update,
    input  wire jbed_pkg::cfg_t              cfg,
    input  wire logic [jbed_pkg::TIME_W-1:0] now_ms,
    input  wire logic                        button1_down,
    input  wire logic                        button2_down,
    input  wire logic [FRAC_BITS:0]          x_mag,
    input  wire logic                        x_neg,
    input  wire logic [FRAC_BITS:0]          y_mag,
    input  wire logic                        y_neg,
    output jbed_pkg::res_t                   res
);
    import jbed_pkg::*;

    localparam int MAG_W = FRAC_BITS + 1;
    localparam int POS_W = FRAC_BITS + 2;
    localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;
    localparam logic [MAG_W-1:0] HALF_FX   = MAG_W'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_W-1:0] SCREEN_FX = MAG_W'((3 << FRAC_BITS) / 10);

    logic              prev_b1_reg;
    logic              prev_b2_reg;
    logic              both_held_reg;
    logic [TIME_W-1:0] both_start_reg;
    logic [TIME_W-1:0] last_stick_reg;

    logic              x_act;
    logic              y_act;
    logic              acc;
    logic              press1;
    logic              press2;
    logic              both_now;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] hold_elapsed;
    logic [TIME_W-1:0] stick_elapsed;
    logic              hold_hit;
    logic              stick_due;
    logic              stick_touch;
    event_t            ev;
    logic [POS_W-1:0]  x_ext;
    logic [POS_W-1:0]  y_ext;
    logic [POS_W-1:0]  x_sgn;
    logic [POS_W-1:0]  y_sgn;
    logic [POS_W-1:0]  x_full;
    logic [POS_W-1:0]  y_full;

    assign x_act = CMP_W'(x_mag) >= CMP_W'(cfg.deadband);
    assign y_act = CMP_W'(y_mag) >= CMP_W'(cfg.deadband);
    assign acc   = CMP_W'(y_mag) > CMP_W'(cfg.accel_threshold);

    assign x_ext  = {1'b0, x_mag};
    assign y_ext  = {1'b0, y_mag};
    assign x_sgn  = x_neg ? -x_ext : x_ext;
    assign y_sgn  = y_neg ? -y_ext : y_ext;
    assign x_full = x_act ? x_sgn : '0;
    assign y_full = y_act ? y_sgn : '0;

    generate
        if (POS_W >= POS_OUT_W) begin : g_pos_trunc
            assign res.x_pos = x_full[POS_OUT_W-1:0];
            assign res.y_pos = y_full[POS_OUT_W-1:0];
        end else begin : g_pos_ext
            assign res.x_pos = {{(POS_OUT_W-POS_W){x_full[POS_W-1]}}, x_full};
            assign res.y_pos = {{(POS_OUT_W-POS_W){y_full[POS_W-1]}}, y_full};
        end
    endgenerate

    assign press1        = button1_down && !prev_b1_reg;
    assign press2        = button2_down && !prev_b2_reg;
    assign both_now      = button1_down && button2_down;
    assign start_eff     = both_held_reg ? both_start_reg : now_ms;
    assign hold_elapsed  = now_ms - start_eff;
    assign stick_elapsed = now_ms - last_stick_reg;
    assign hold_hit      = both_now && (hold_elapsed >= TIME_W'(cfg.hold_time_ms));
    assign stick_due     = stick_elapsed >= TIME_W'(cfg.repeat_delay_ms);

    always_comb begin
        ev          = EV_NONE;
        stick_touch = 1'b0;
        priority if (hold_hit) begin
            ev = EV_BOTH_HOLD;
        end else if (press1) begin
            ev = EV_BUTTON1;
        end else if (press2) begin
            ev = EV_BUTTON2;
        end else if (stick_due) begin
            if (x_act) begin
                stick_touch = 1'b1;
                if (!x_neg && x_mag > HALF_FX) begin
                    ev = EV_RIGHT;
                end else if (x_neg && x_mag > HALF_FX) begin
                    ev = EV_LEFT;
                end else if (!x_neg && x_mag > SCREEN_FX) begin
                    ev = EV_SCR_RIGHT;
                end else if (x_neg && x_mag > SCREEN_FX) begin
                    ev = EV_SCR_LEFT;
                end
            end
            if (ev == EV_NONE && y_act) begin
                stick_touch = 1'b1;
                if (!y_neg && y_mag > HALF_FX) begin
                    ev = EV_UP;
                end else if (y_neg && y_mag > HALF_FX) begin
                    ev = EV_DOWN;
                end
            end
        end else begin
            ev = EV_NONE;
        end
    end

    assign res.event_code   = ev;
    assign res.x_engaged    = x_act;
    assign res.y_engaged    = y_act;
    assign res.accel_active = acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_b1_reg    <= 1'b0;
            prev_b2_reg    <= 1'b0;
            both_held_reg  <= 1'b0;
            both_start_reg <= '0;
            last_stick_reg <= '0;
        end else if (update) begin
            prev_b1_reg    <= button1_down;
            prev_b2_reg    <= button2_down;
            both_held_reg  <= both_now;
            both_start_reg <= both_now ? start_eff : '0;
            if (stick_touch) begin
                last_stick_reg <= now_ms;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/joystick_button_event_decoder.sv -----
// Top level of the joystick and button event decoder.
// Each sample is scaled on the x axis and then the y axis by the single bit-serial divider,
// then decided and registered at the output; a new sample is accepted only in idle, after
// the previous result has been taken into the output register.
// Reset (synchronous, active low) clears the sequencer, the output valid, the button and
// timer state, and loads every configuration register with its default.
`default_nettype none

module joystick_button_event_decoder #(
    parameter int ADC_BITS  = jbed_pkg::ADC_BITS_DEF,
    parameter int FRAC_BITS = jbed_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [jbed_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [jbed_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [jbed_pkg::TIME_W-1:0]     s_now_ms,
    input  wire logic [ADC_BITS-1:0]             s_x_raw,
    input  wire logic [ADC_BITS-1:0]             s_y_raw,
    input  wire logic                            s_button1_down,
    input  wire logic                            s_button2_down,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [jbed_pkg::EVENT_W-1:0]         m_event_code,
    output logic signed [jbed_pkg::POS_OUT_W-1:0] m_x_pos,
    output logic signed [jbed_pkg::POS_OUT_W-1:0] m_y_pos,
    output logic                                 m_x_engaged,
    output logic                                 m_y_engaged,
    output logic                                 m_accel_active
);
    import jbed_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_XDIV = 4'b0010,
        ST_YDIV = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    cfg_t                cfg;
    res_t                res;
    res_t                res_reg;
    logic                m_valid_reg;

    logic [TIME_W-1:0]   now_reg;
    logic [ADC_BITS-1:0] y_raw_reg;
    logic                b1_reg;
    logic                b2_reg;
    logic [FRAC_BITS:0]  x_mag_reg;
    logic                x_neg_reg;

    logic                ax_start;
    logic                ax_done;
    logic [ADC_BITS-1:0] ax_raw;
    logic [CENTER_W-1:0] ax_center;
    logic [SPAN_W-1:0]   ax_span;
    logic [FRAC_BITS:0]  ax_mag;
    logic                ax_neg;
    logic                accept;
    logic                update;
    logic                out_free;

    jbed_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign update   = (state_reg == ST_DONE) && out_free;

    // The x axis starts straight from the ports; the y axis from the latched sample.
    assign ax_start  = accept || ((state_reg == ST_XDIV) && ax_done);
    assign ax_raw    = (state_reg == ST_IDLE) ? s_x_raw : y_raw_reg;
    assign ax_center = (state_reg == ST_IDLE) ? cfg.x_center : cfg.y_center;
    assign ax_span   = (state_reg == ST_IDLE) ? cfg.x_span : cfg.y_span;

    jbed_axis_div #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_axis (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ax_start),
        .raw     (ax_raw),
        .center  (ax_center),
        .span    (ax_span),
        .done    (ax_done),
        .mag     (ax_mag),
        .neg     (ax_neg)
    );

    jbed_event_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_event (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .update       (update),
        .cfg          (cfg),
        .now_ms       (now_reg),
        .button1_down (b1_reg),
        .button2_down (b2_reg),
        .x_mag        (x_mag_reg),
        .x_neg        (x_neg_reg),
        .y_mag        (ax_mag),
        .y_neg        (ax_neg),
        .res          (res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_XDIV;
                end
            end
            ST_XDIV: begin
                if (ax_done) begin
                    state_next = ST_YDIV;
                end
            end
            ST_YDIV: begin
                if (ax_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (update) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg   <= s_now_ms;
            y_raw_reg <= s_y_raw;
            b1_reg    <= s_button1_down;
            b2_reg    <= s_button2_down;
        end
        if ((state_reg == ST_XDIV) && ax_done) begin
            x_mag_reg <= ax_mag;
            x_neg_reg <= ax_neg;
        end
        if (update) begin
            res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_code   = res_reg.event_code;
    assign m_x_pos        = res_reg.x_pos;
    assign m_y_pos        = res_reg.y_pos;
    assign m_x_engaged    = res_reg.x_engaged;
    assign m_y_engaged    = res_reg.y_engaged;
    assign m_accel_active = res_reg.accel_active;

endmodule

`default_nettype wire
